// ===== hdl/ptb_pkg.sv =====
// Shared constants for the periodic timer bank.
// Holds field widths and operation/result codes; depends on nothing.
`default_nettype none

package ptb_pkg;

    // Fixed field widths of the transfer payloads
    localparam int PERIOD_W = 16;
    localparam int SLOT_W   = 4;

    // Operation codes on the input channel
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Result kinds on the output channel
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/ptb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used by the timer bank for per-slot interval and count.
`default_nettype none

module ptb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/ptb_step_unit.sv =====
// Shared count step: advance one slot's count and compare with its interval.
// Standalone arithmetic; instanced once by the timer bank top level.
`default_nettype none

module ptb_step_unit #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic [COUNT_BITS-1:0] count,
    input  wire logic [COUNT_BITS-1:0] period,
    output logic      [COUNT_BITS-1:0] count_next,
    output logic                       expire
);

    logic [COUNT_BITS-1:0] count_inc;

    always_comb
    begin
        count_inc  = count + COUNT_BITS'(1);
        expire     = (count_inc == period);
        count_next = expire ? '0 : count_inc;
    end

endmodule

`default_nettype wire

// ===== hdl/periodic_timer_bank_top.sv =====
// Periodic timer bank, top level: sequencer, slot flags and output register.
// Depends on ptb_pkg, ptb_ram and ptb_step_unit.
`default_nettype none

// A bank of SLOTS periodic timers. A start transfer (opcode 1) claims the
// lowest free slot with the given interval and answers with one reply
// (kind 0); a zero interval or a full bank answers with failed set and
// slot 0. Slots are never released. A tick transfer (opcode 0) advances the
// count of every active slot; each slot whose count reaches its interval
// wraps to zero and gives an expiry (kind 1), in ascending slot order, with
// last set on the final one. A tick with no expiry gives no transfer.
// Interval and count of each slot live in one RAM, read one slot per cycle
// unless a second expiry must wait for room in the output register, and
// updated through a single shared increment-and-compare unit. A tick is
// accepted, walks the slots in order, then flushes the held expiry; a start
// with a nonzero interval searches the slots in order for a free one, then
// replies. A stalled output delays a waiting result. The input is stalled
// for the whole of an item's work. The output register lets a new item be
// taken while the previous result is still waiting. Intervals wider than
// COUNT_BITS saturate to the largest count value; slot numbers keep their
// low four bits. No clearing pass is needed after reset: a slot's RAM word
// is written on claim before it is ever read.

module periodic_timer_bank_top #(
    parameter int SLOTS      = 10,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          opcode,
    input  wire logic [ptb_pkg::PERIOD_W-1:0]  period_ticks,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               kind,
    output logic      [ptb_pkg::SLOT_W-1:0]    slot,
    output logic                               failed,
    output logic                               last
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORD_W = 2 * COUNT_BITS;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_REPLY  = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    // Control state
    logic [2:0]             state_reg,        state_next;
    logic [IDX_W-1:0]       idx_reg,          idx_next;
    logic [SLOTS-1:0]       act_reg,          act_next;
    logic                   pend_valid_reg,   pend_valid_next;
    logic                   out_valid_reg,    out_valid_next;

    // Payload holding registers
    logic [IDX_W-1:0]             pend_slot_reg,    pend_slot_next;
    logic [ptb_pkg::SLOT_W-1:0]   reply_slot_reg,   reply_slot_next;
    logic                         reply_failed_reg, reply_failed_next;
    logic [COUNT_BITS-1:0]        period_reg,       period_next;
    logic                         out_kind_reg,     out_kind_next;
    logic [ptb_pkg::SLOT_W-1:0]   out_slot_reg,     out_slot_next;
    logic                         out_failed_reg,   out_failed_next;
    logic                         out_last_reg,     out_last_next;

    // RAM port
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;

    // Shared step unit
    logic [COUNT_BITS-1:0]  step_count_next;
    logic                   step_expire;

    logic [COUNT_BITS-1:0]  period_sat;
    logic                   room;
    logic                   slot_live;
    logic                   hit;
    logic                   blocked;

    // Bring the 16-bit interval to the count width, saturating if narrower.
    generate
        if (COUNT_BITS >= ptb_pkg::PERIOD_W)
        begin : g_period_wide
            assign period_sat = COUNT_BITS'(period_ticks);
        end
        else
        begin : g_period_narrow
            localparam logic [ptb_pkg::PERIOD_W-1:0] CNT_MAX =
                ptb_pkg::PERIOD_W'((64'd1 << COUNT_BITS) - 64'd1);
            assign period_sat = (period_ticks > CNT_MAX) ? COUNT_BITS'(CNT_MAX)
                                                         : COUNT_BITS'(period_ticks);
        end
    endgenerate

    // Interval in the upper half of each word, count in the lower half.
    ptb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptb_step_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .count      (ram_rdata[COUNT_BITS-1:0]),
        .period     (ram_rdata[WORD_W-1:COUNT_BITS]),
        .count_next (step_count_next),
        .expire     (step_expire)
    );

    // The output register can take a new result this cycle.
    assign room      = !out_valid_reg || !out_stall;
    assign slot_live = act_reg[idx_reg];
    assign hit       = slot_live && step_expire;
    // A second expiry cannot be held while the first still waits for room.
    assign blocked   = hit && pend_valid_reg && !room;

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        act_next          = act_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        reply_slot_next   = reply_slot_reg;
        reply_failed_next = reply_failed_reg;
        period_next       = period_reg;

        // Drop the held result once it has been transferred.
        out_valid_next    = out_valid_reg && out_stall;
        out_kind_next     = out_kind_reg;
        out_slot_next     = out_slot_reg;
        out_failed_next   = out_failed_reg;
        out_last_next     = out_last_reg;

        ram_we            = 1'b0;
        ram_waddr         = idx_reg;
        ram_wdata         = {ram_rdata[WORD_W-1:COUNT_BITS], step_count_next};
        ram_raddr         = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = '0;
                    if (opcode == ptb_pkg::OP_START)
                    begin
                        if (period_ticks == '0)
                        begin
                            reply_failed_next = 1'b1;
                            reply_slot_next   = '0;
                            state_next        = ST_REPLY;
                        end
                        else
                        begin
                            period_next = period_sat;
                            state_next  = ST_SEARCH;
                        end
                    end
                    else
                    begin
                        // Issue the read of slot zero; its word arrives next cycle.
                        ram_raddr  = '0;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (!slot_live)
                begin
                    // Claim the slot: store interval, clear count.
                    act_next[idx_reg] = 1'b1;
                    ram_we            = 1'b1;
                    ram_wdata         = {period_reg, {COUNT_BITS{1'b0}}};
                    reply_slot_next   = ptb_pkg::SLOT_W'(idx_reg);
                    reply_failed_next = 1'b0;
                    state_next        = ST_REPLY;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    reply_slot_next   = '0;
                    reply_failed_next = 1'b1;
                    state_next        = ST_REPLY;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_REPLY:
            begin
                if (room)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = ptb_pkg::KIND_REPLY;
                    out_slot_next   = reply_slot_reg;
                    out_failed_next = reply_failed_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_WALK:
            begin
                if (blocked)
                begin
                    // Hold: reread the same slot, write nothing.
                    ram_raddr = idx_reg;
                end
                else
                begin
                    ram_we    = slot_live;
                    ram_raddr = idx_reg + IDX_W'(1);
                    if (hit)
                    begin
                        // Release the older expiry; it cannot be the last.
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = ptb_pkg::KIND_EXPIRY;
                            out_slot_next   = ptb_pkg::SLOT_W'(pend_slot_reg);
                            out_failed_next = 1'b0;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (room)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = ptb_pkg::KIND_EXPIRY;
                    out_slot_next   = ptb_pkg::SLOT_W'(pend_slot_reg);
                    out_failed_next = 1'b0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            act_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            act_reg        <= act_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pend_slot_reg    <= pend_slot_next;
        reply_slot_reg   <= reply_slot_next;
        reply_failed_reg <= reply_failed_next;
        period_reg       <= period_next;
        out_kind_reg     <= out_kind_next;
        out_slot_reg     <= out_slot_next;
        out_failed_reg   <= out_failed_next;
        out_last_reg     <= out_last_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign slot      = out_slot_reg;
    assign failed    = out_failed_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire
